### src/mse_pkg.sv
package mse_pkg;

   localparam int DEPTH_DEFAULT      = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH        = 4;

   // classification attached to each item by the front end
   typedef struct packed {
      logic is_last;
      logic drop;
   } mse_tag_type;

   localparam int TAG_WIDTH = $bits(mse_tag_type);

endpackage

### src/mse_req_if.sv
interface mse_req_if #(
   parameter int DATA_WIDTH = 32
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] value;
   logic                  is_last;

   modport source (output valid, output value, output is_last, input ready);
   modport sink   (input valid, input value, input is_last, output ready);
endinterface

### src/mse_rsp_if.sv
interface mse_rsp_if #(
   parameter int DATA_WIDTH = 32
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] sorted_value;
   logic                  last_out;
   logic                  overflowed;

   modport source (output valid, output sorted_value, output last_out, output overflowed,
                   input ready);
   modport sink   (input valid, input sorted_value, input last_out, input overflowed,
                   output ready);
endinterface

### src/mse_front.sv
module mse_front #(
   parameter int DEPTH      = mse_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = mse_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   mse_req_if.sink               req,
   output logic                  push_valid,
   input  logic                  push_ready,
   output logic [DATA_WIDTH-1:0] push_value,
   output mse_pkg::mse_tag_type  push_tag
);
   import mse_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;
   logic             transfer;
   logic             full;

   assign full       = (fill_ff == CNT_W'(DEPTH));
   assign transfer   = req.valid && push_ready;
   assign req.ready  = push_ready;
   assign push_valid = req.valid;
   assign push_value = req.value;

   always_comb begin
      push_tag.is_last = req.is_last;
      push_tag.drop    = full;
   end

   // run fill level, mirrors what the back end will have stored
   always_comb begin
      fill_in = fill_ff;
      if (transfer) begin
         if (req.is_last) begin
            fill_in = '0;
         end else if (!full) begin
            fill_in = fill_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

endmodule

### src/mse_queue.sv
module mse_queue #(
   parameter int WIDTH = 34
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import mse_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [LVL_W-1:0] level_ff;
   logic [LVL_W-1:0] level_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (level_ff != LVL_W'(QUEUE_DEPTH));
   assign pop_valid  = (level_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + LVL_W'(1);
      end else if (do_pop && !do_push) begin
         level_in = level_ff - LVL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### src/mse_back.sv
module mse_back #(
   parameter int DEPTH      = mse_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = mse_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  logic [DATA_WIDTH-1:0] pop_value,
   input  mse_pkg::mse_tag_type  pop_tag,
   mse_rsp_if.source             rsp
);
   import mse_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int WID_W = CNT_W + 1;
   localparam int SUM_W = CNT_W + 2;

   typedef enum logic [3:0] {
      ST_LOAD  = 4'b0001,
      ST_GAP   = 4'b0010,
      ST_MERGE = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             ovf_ff;
   logic             ovf_in;
   logic             src_sel_ff;
   logic             src_sel_in;
   logic [WID_W-1:0] width_ff;
   logic [WID_W-1:0] width_in;
   logic [CNT_W-1:0] a_ff;
   logic [CNT_W-1:0] a_in;
   logic [CNT_W-1:0] b_ff;
   logic [CNT_W-1:0] b_in;
   logic [CNT_W-1:0] mid_ff;
   logic [CNT_W-1:0] mid_in;
   logic [CNT_W-1:0] hi_ff;
   logic [CNT_W-1:0] hi_in;
   logic [CNT_W-1:0] k_ff;
   logic [CNT_W-1:0] k_in;

   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [DATA_WIDTH-1:0] out_value_ff;
   logic [DATA_WIDTH-1:0] out_value_in;
   logic                  out_last_ff;
   logic                  out_last_in;
   logic                  out_ovf_ff;
   logic                  out_ovf_in;

   logic [DATA_WIDTH-1:0] mem0 [DEPTH];
   logic [DATA_WIDTH-1:0] mem1 [DEPTH];
   logic [DATA_WIDTH-1:0] rd0a_ff;
   logic [DATA_WIDTH-1:0] rd0b_ff;
   logic [DATA_WIDTH-1:0] rd1a_ff;
   logic [DATA_WIDTH-1:0] rd1b_ff;
   logic                  we0;
   logic                  we1;
   logic [IDX_W-1:0]      waddr;
   logic [DATA_WIDTH-1:0] wdata;

   logic [DATA_WIDTH-1:0] head_a;
   logic [DATA_WIDTH-1:0] head_b;
   logic                  take_left;
   logic [CNT_W-1:0]      n_new;
   logic [SUM_W-1:0]      n_ext;
   logic [SUM_W-1:0]      w_s;
   logic [SUM_W-1:0]      w2_s;
   logic [SUM_W-1:0]      seg_mid_s;
   logic [SUM_W-1:0]      seg_hi_s;
   logic [SUM_W-1:0]      pass_mid_s;
   logic [SUM_W-1:0]      pass_hi_s;

   assign head_a    = src_sel_ff ? rd1a_ff : rd0a_ff;
   assign head_b    = src_sel_ff ? rd1b_ff : rd0b_ff;
   assign pop_ready = (state_ff == ST_LOAD);

   assign n_new = pop_tag.drop ? count_ff : count_ff + CNT_W'(1);
   assign n_ext = SUM_W'(count_ff);
   assign w_s   = SUM_W'(width_ff);
   assign w2_s  = w_s << 1;

   // bounds of the next pair of runs, clipped to the run length
   assign seg_mid_s  = (SUM_W'(hi_ff) + w_s < n_ext) ? SUM_W'(hi_ff) + w_s : n_ext;
   assign seg_hi_s   = (SUM_W'(hi_ff) + w2_s < n_ext) ? SUM_W'(hi_ff) + w2_s : n_ext;
   assign pass_mid_s = (w2_s < n_ext) ? w2_s : n_ext;
   assign pass_hi_s  = ((w2_s << 1) < n_ext) ? (w2_s << 1) : n_ext;

   always_comb begin
      if (a_ff >= mid_ff) begin
         take_left = 1'b0;
      end else if (b_ff >= hi_ff) begin
         take_left = 1'b1;
      end else begin
         take_left = ($signed(head_a) <= $signed(head_b));
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      src_sel_in   = src_sel_ff;
      width_in     = width_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      k_in         = k_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_ovf_in   = out_ovf_ff;
      we0          = 1'b0;
      we1          = 1'b0;
      waddr        = k_ff[IDX_W-1:0];
      wdata        = take_left ? head_a : head_b;

      unique case (state_ff)
         ST_LOAD: begin
            waddr = count_ff[IDX_W-1:0];
            wdata = pop_value;
            if (pop_valid) begin
               if (pop_tag.drop) begin
                  ovf_in = 1'b1;
               end else begin
                  we0      = 1'b1;
                  count_in = n_new;
               end
               if (pop_tag.is_last) begin
                  state_in   = ST_GAP;
                  src_sel_in = 1'b0;
                  width_in   = WID_W'(1);
                  a_in       = '0;
                  mid_in     = CNT_W'(1);
                  b_in       = CNT_W'(1);
                  hi_in      = (n_new >= CNT_W'(2)) ? CNT_W'(2) : n_new;
                  k_in       = '0;
               end
            end
         end
         ST_GAP: begin
            // lets the last write land before the first read of the next pass
            if (w_s >= n_ext) begin
               state_in = ST_EMIT;
               a_in     = '0;
            end else begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            we0  = src_sel_ff;
            we1  = !src_sel_ff;
            a_in = take_left ? a_ff + CNT_W'(1) : a_ff;
            b_in = take_left ? b_ff : b_ff + CNT_W'(1);
            k_in = k_ff + CNT_W'(1);
            if (k_ff + CNT_W'(1) == hi_ff) begin
               if (hi_ff == count_ff) begin
                  state_in   = ST_GAP;
                  src_sel_in = !src_sel_ff;
                  width_in   = w2_s[WID_W-1:0];
                  a_in       = '0;
                  mid_in     = pass_mid_s[CNT_W-1:0];
                  b_in       = pass_mid_s[CNT_W-1:0];
                  hi_in      = pass_hi_s[CNT_W-1:0];
                  k_in       = '0;
               end else begin
                  a_in   = hi_ff;
                  mid_in = seg_mid_s[CNT_W-1:0];
                  b_in   = seg_mid_s[CNT_W-1:0];
                  hi_in  = seg_hi_s[CNT_W-1:0];
                  k_in   = hi_ff;
               end
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in = 1'b1;
               out_value_in = head_a;
               out_last_in  = (a_ff + CNT_W'(1) == count_ff);
               out_ovf_in   = ovf_ff;
               a_in         = a_ff + CNT_W'(1);
               if (a_ff + CNT_W'(1) == count_ff) begin
                  state_in = ST_LOAD;
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_sel_ff   <= src_sel_in;
      width_ff     <= width_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      mid_ff       <= mid_in;
      hi_ff        <= hi_in;
      k_ff         <= k_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      out_ovf_ff   <= out_ovf_in;
   end

   // ping-pong buffers, one write and two registered reads each
   always_ff @(posedge clock) begin
      if (we0) begin
         mem0[waddr] <= wdata;
      end
      rd0a_ff <= mem0[a_in[IDX_W-1:0]];
      rd0b_ff <= mem0[b_in[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (we1) begin
         mem1[waddr] <= wdata;
      end
      rd1a_ff <= mem1[a_in[IDX_W-1:0]];
      rd1b_ff <= mem1[b_in[IDX_W-1:0]];
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.sorted_value = out_value_ff;
   assign rsp.last_out     = out_last_ff;
   assign rsp.overflowed   = out_ovf_ff;

endmodule

### src/merge_sort_engine_unit.sv
// Stable ascending sort of a run of signed values. Values arrive one per
// transfer on req_chan at up to one per cycle; the transfer with is_last set
// closes the run. Up to DEPTH values are kept, further ones are dropped and
// every result of that run then carries overflowed. A four-entry queue sits
// between the input and the sort core, so a following run can start
// arriving while the current one is sorted. A run of n values is merged in
// ceil(log2(n)) bottom-up passes between two buffers, one element per cycle
// per pass with a gap state between passes, bound by the single write port of
// each buffer; results then leave at one per cycle while rsp_chan accepts
// them, with last_out on the final one.
module merge_sort_engine_unit #(
   parameter int DEPTH      = mse_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = mse_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   mse_req_if.sink   req_chan,
   mse_rsp_if.source rsp_chan
);
   import mse_pkg::*;

   localparam int ITEM_W = DATA_WIDTH + TAG_WIDTH;

   logic                  push_valid;
   logic                  push_ready;
   logic [DATA_WIDTH-1:0] push_value;
   mse_tag_type           push_tag;
   logic                  pop_valid;
   logic                  pop_ready;
   logic [ITEM_W-1:0]     pop_data;
   logic [DATA_WIDTH-1:0] pop_value;
   mse_tag_type           pop_tag;

   mse_front #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_value (push_value),
      .push_tag   (push_tag)
   );

   mse_queue #(
      .WIDTH (ITEM_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_tag, push_value}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign pop_value = pop_data[DATA_WIDTH-1:0];
   assign pop_tag   = pop_data[ITEM_W-1:DATA_WIDTH];

   mse_back #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_value (pop_value),
      .pop_tag   (pop_tag),
      .rsp       (rsp_chan)
   );

endmodule

### src/mse_checker.sv
module mse_checker #(
   parameter int DEPTH      = mse_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = mse_pkg::DATA_WIDTH_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DATA_WIDTH-1:0] rsp_value,
   input logic                  rsp_last,
   input logic                  rsp_ovf
);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                  transfer;
   logic                  in_run_ff;
   logic [DATA_WIDTH-1:0] prev_value_ff;
   logic                  prev_ovf_ff;
   logic [CNT_W-1:0]      run_len_ff;

   assign transfer = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_run_ff  <= 1'b0;
         run_len_ff <= '0;
      end else if (transfer) begin
         in_run_ff  <= !rsp_last;
         run_len_ff <= rsp_last ? '0 : run_len_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (transfer) begin
         prev_value_ff <= rsp_value;
         prev_ovf_ff   <= rsp_ovf;
      end
   end

   // results within a run come out in ascending signed order
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      transfer && in_run_ff |-> $signed(rsp_value) >= $signed(prev_value_ff))
      else $error("results out of order within a run");

   a_ovf_const: assert property (@(posedge clock) disable iff (reset)
      transfer && in_run_ff |-> rsp_ovf == prev_ovf_ff)
      else $error("overflowed changes within a run");

   a_run_len: assert property (@(posedge clock) disable iff (reset)
      transfer |-> run_len_ff < CNT_W'(DEPTH))
      else $error("run longer than the buffer depth");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

endmodule

bind merge_sort_engine_unit mse_checker #(
   .DEPTH      (DEPTH),
   .DATA_WIDTH (DATA_WIDTH)
) u_mse_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_value (rsp_chan.sorted_value),
   .rsp_last  (rsp_chan.last_out),
   .rsp_ovf   (rsp_chan.overflowed)
);
